// ----- src/fcsm_pkg.sv -----
// Package: payload types and binary16 helper functions for the complex scale multiplier.
package fcsm_pkg;

   typedef struct packed {
      logic [63:0] elem_real_bits;
      logic [63:0] elem_imag_bits;
   } req_word_type;

   typedef struct packed {
      logic [15:0] elem_real_half;
      logic [15:0] elem_imag_half;
      logic [15:0] prod_real_half;
      logic [15:0] prod_imag_half;
   } rsp_word_type;

   localparam logic [0:0] CSR_SCALAR_REAL = 1'd0;
   localparam logic [0:0] CSR_SCALAR_IMAG = 1'd1;
   localparam logic [15:0] HALF_INVALID = 16'h7FFF;
   localparam logic [15:0] HALF_QUIET = 16'h0200;

   function automatic logic half_is_nan(input logic [15:0] h);
      half_is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
   endfunction

   function automatic logic half_is_inf(input logic [15:0] h);
      half_is_inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
   endfunction

   // Round sign * mag * 2^(ex-23) to binary16, nearest even.
   // mag is a 24-bit magnitude whose lsb weighs 2^(ex-23).
   // Caller pre-normalizes: mag[23] is the leading one or the value is subnormal-scaled.
   function automatic logic [15:0] round_norm(input logic sgn, input logic signed [7:0] ex,
                                              input logic [23:0] mag, input logic sticky);
      // value = mag[23].mag[22:0] * 2^ex, mag[23]=1 if nonzero
      logic [5:0]  sh;
      logic [24:0] m;
      logic [10:0] keep;
      logic        g;
      logic        st;
      logic [15:0] h;
      logic [24:0] tmp;
      sh = 6'd0;
      m = {mag, sticky};
      if (mag == 24'd0) begin
         round_norm = {sgn, 15'd0};
      end else begin
         if (ex < -8'sd14) begin
            sh = (ex < -8'sd40) ? 6'd26 : 6'(-8'sd14 - ex);
         end
         tmp = m >> sh;
         st = ((m & ((25'd1 << sh) - 25'd1)) != 25'd0);
         // tmp[24:14] = 11 kept bits, tmp[13] guard, tmp[12:0] + st sticky
         keep = tmp[24:14];
         g = tmp[13];
         st = st | (tmp[12:0] != 13'd0);
         if (sh != 6'd0 || ex < -8'sd14) begin
            h = {5'd0, keep};
         end else begin
            h = {1'b0, 5'(ex + 8'sd14), 10'd0} + {5'd0, 1'b0, keep[9:0]};
            h = ({11'd0, 5'd0} | h);
            h = h + 16'h0400;
         end
         if (g && (st || keep[0])) h = h + 16'd1;
         if (ex > 8'sd15 || h > 16'h7C00) h = 16'h7C00;
         round_norm = {sgn, h[14:0]};
      end
   endfunction

   // binary64 bits to binary16 bits
   function automatic logic [15:0] dbl_to_half(input logic [63:0] b);
      logic        s;
      logic [10:0] ex;
      logic signed [12:0] e;
      s = b[63];
      ex = b[62:52];
      e = 13'(ex) - 13'sd1023;
      if (ex == 11'h7FF) begin
         dbl_to_half = (b[51:0] != 52'd0) ? {s, 5'h1F, 1'b1, b[50:42]} : {s, 15'h7C00};
      end else if (ex == 11'd0) begin
         dbl_to_half = {s, 15'd0};
      end else if (e > 13'sd15) begin
         dbl_to_half = {s, 15'h7C00};
      end else if (e < -13'sd40) begin
         dbl_to_half = {s, 15'd0};
      end else begin
         dbl_to_half = round_norm(s, 8'(e), {1'b1, b[51:29]}, b[28:0] != 29'd0);
      end
   endfunction

   // Unpack a finite half into significand and biased exponent (1 for subnormals) of lsb-weighted form.
   function automatic logic [10:0] half_sig(input logic [15:0] h);
      half_sig = {(h[14:10] != 5'd0), h[9:0]};
   endfunction

   function automatic logic [4:0] half_exp(input logic [15:0] h);
      half_exp = (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
   endfunction

endpackage

// ----- src/fcsm_mul.sv -----
// Binary16 multiplier: 22-bit product in stage one, normalize and round in stage two.
module fcsm_mul
   import fcsm_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  logic [15:0] a,
   input  logic [15:0] b,
   output logic [15:0] p
);
   logic [21:0] prod_ff, prod_in;
   logic signed [7:0] ex_ff, ex_in;
   logic        sgn_ff;
   logic        spec_ff, spec_in;
   logic [15:0] spec_val_ff, spec_val_in;
   logic [4:0]  lz;
   logic [23:0] norm;
   logic [15:0] p_ff;

   always_comb begin
      prod_in = half_sig(a) * half_sig(b);
      // value = prod * 2^(ea+eb-30-20) with leading at bit 21 -> exponent ea+eb-30+1
      ex_in = 8'(half_exp(a)) + 8'(half_exp(b)) - 8'sd29;
      spec_in = 1'b1;
      spec_val_in = {a[15] ^ b[15], 15'd0};
      if (half_is_nan(a)) spec_val_in = a | HALF_QUIET;
      else if (half_is_nan(b)) spec_val_in = b | HALF_QUIET;
      else if (half_is_inf(a) || half_is_inf(b)) begin
         if (a[14:0] == 15'd0 || b[14:0] == 15'd0) spec_val_in = HALF_INVALID;
         else spec_val_in = {a[15] ^ b[15], 15'h7C00};
      end else spec_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         ex_ff <= ex_in;
         sgn_ff <= a[15] ^ b[15];
         spec_ff <= spec_in;
         spec_val_ff <= spec_val_in;
      end
   end

   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 22; i++) begin
         if (prod_ff[i]) lz = 5'(21 - i);
      end
      norm = {prod_ff << lz, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= spec_ff ? spec_val_ff
                         : round_norm(sgn_ff, ex_ff - 8'(lz), norm, 1'b0);
      end
   end
   assign p = p_ff;
endmodule

// ----- src/fcsm_add.sv -----
// Binary16 adder: align in stage one, add in stage two, normalize and round in stage three.
module fcsm_add
   import fcsm_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  logic [15:0] a,
   input  logic [15:0] b_raw,
   input  logic        sub,
   output logic [15:0] s
);
   logic [15:0] b;
   logic        swap;
   logic [15:0] x, y;
   logic [5:0]  d;
   logic [40:0] xa_ff, ya_ff;
   logic [4:0]  ex_ff, ex2_ff;
   logic        sx_ff, sy_ff;
   logic        spec_ff, spec_in, spec2_ff;
   logic [15:0] sv_ff, sv_in, sv2_ff;
   logic [41:0] sum_ff;
   logic        ssum_ff;
   logic        zero_ff;
   logic [5:0]  lz;
   logic [41:0] nrm;
   logic [15:0] s_ff;

   always_comb begin
      b = b_raw ^ {sub & ~half_is_nan(b_raw), 15'd0};
      swap = (b[14:0] > a[14:0]);
      x = swap ? b : a;
      y = swap ? a : b;
      d = 6'(half_exp(x) - half_exp(y));
      spec_in = 1'b1;
      sv_in = 16'd0;
      if (half_is_nan(a)) sv_in = a | HALF_QUIET;
      else if (half_is_nan(b_raw)) sv_in = b_raw | HALF_QUIET;
      else if (half_is_inf(a) && half_is_inf(b)) sv_in = (a[15] == b[15]) ? a : HALF_INVALID;
      else if (half_is_inf(a)) sv_in = a;
      else if (half_is_inf(b)) sv_in = b;
      else spec_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff <= {half_sig(x), 30'd0};
         ya_ff <= {half_sig(y), 30'd0} >> d;
         ex_ff <= half_exp(x);
         sx_ff <= x[15];
         sy_ff <= y[15];
         spec_ff <= spec_in;
         sv_ff <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= (sx_ff == sy_ff) ? {1'b0, xa_ff} + {1'b0, ya_ff}
                                    : {1'b0, xa_ff} - {1'b0, ya_ff};
         ssum_ff <= sx_ff;
         // exact cancel gives +0 except -0 + -0
         zero_ff <= (xa_ff == ya_ff) && (sx_ff != sy_ff);
         ex2_ff <= ex_ff;
         spec2_ff <= spec_ff;
         sv2_ff <= sv_ff;
      end
   end

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 42; i++) begin
         if (sum_ff[i]) lz = 6'(41 - i);
      end
      nrm = sum_ff << lz;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (spec2_ff) s_ff <= sv2_ff;
         else if (zero_ff) s_ff <= 16'd0;
         else if (sum_ff == 42'd0) s_ff <= {ssum_ff, 15'd0};
         else s_ff <= round_norm(ssum_ff, 8'(ex2_ff) - 8'sd14 - 8'(lz), nrm[41:18],
                                 nrm[17:0] != 18'd0);
      end
   end
   assign s = s_ff;
endmodule

// ----- src/fp16_complex_scale_multiply_core.sv -----
// Top level: binary16 complex scale multiplier pipeline.
//  channel | dir | payload        | handshake
//  req     | in  | req_word_type  | req_valid / req_ready
//  rsp     | out | rsp_word_type  | rsp_valid / rsp_ready
//  csr     | in  | 64-bit write   | csr_write_enable
// One word per cycle while the output is not stalled; stages: convert, multiply (2), add (3), output register.
// Reset clears the valid bits and both scalar registers (+0.0).
// All stages advance together; a stalled output holds the whole pipeline.
module fp16_complex_scale_multiply_core
   import fcsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_data
);
   localparam int Depth = 7;
   logic [63:0] br_ff, bi_ff;
   logic [15:0] ar_ff, ai_ff, hbr_ff, hbi_ff;
   logic [Depth-1:0] vld_ff;
   logic adv;
   logic [15:0] m0, m1, m2, m3, pr, pi;
   logic [15:0] er_d [5], ei_d [5];

   assign adv = ~vld_ff[Depth-1] | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         br_ff <= 64'd0;
         bi_ff <= 64'd0;
         vld_ff <= '0;
      end else begin
         if (csr_write_enable && csr_index == CSR_SCALAR_REAL) br_ff <= csr_data;
         if (csr_write_enable && csr_index == CSR_SCALAR_IMAG) bi_ff <= csr_data;
         if (adv) vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ar_ff <= dbl_to_half(req_word.elem_real_bits);
         ai_ff <= dbl_to_half(req_word.elem_imag_bits);
         hbr_ff <= dbl_to_half(br_ff);
         hbi_ff <= dbl_to_half(bi_ff);
         er_d[0] <= ar_ff;
         ei_d[0] <= ai_ff;
         for (int i = 1; i < 5; i++) begin
            er_d[i] <= er_d[i-1];
            ei_d[i] <= ei_d[i-1];
         end
         rsp_word <= '{elem_real_half: er_d[4], elem_imag_half: ei_d[4],
                       prod_real_half: pr, prod_imag_half: pi};
      end
   end

   fcsm_mul u_m0 (.clock, .adv, .a(ar_ff), .b(hbr_ff), .p(m0));
   fcsm_mul u_m1 (.clock, .adv, .a(ai_ff), .b(hbi_ff), .p(m1));
   fcsm_mul u_m2 (.clock, .adv, .a(ar_ff), .b(hbi_ff), .p(m2));
   fcsm_mul u_m3 (.clock, .adv, .a(ai_ff), .b(hbr_ff), .p(m3));
   fcsm_add u_ar (.clock, .adv, .a(m0), .b_raw(m1), .sub(1'b1), .s(pr));
   fcsm_add u_ai (.clock, .adv, .a(m2), .b_raw(m3), .sub(1'b0), .s(pi));

   assign rsp_valid = vld_ff[Depth-1];
endmodule

// ----- src/fcsm_checker.sv -----
// Port checker for the complex scale multiplier, bound to the top level.
module fcsm_props
   import fcsm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word)) else $error("rsp dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("stall without pending word");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("valid after reset");
endmodule

bind fp16_complex_scale_multiply_core fcsm_props u_fcsm_props (.*);

// ----- sim/fcsm_checker.sv -----
// Checker: predicts each product word from the accepted element and compares the results.
module fcsm_checker
   import fcsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_data,
   output int           mismatch_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0]  scale_re;
   logic [63:0]  scale_im;
   rsp_word_type product_queue[$];

   // binary64 bits to binary16, nearest even
   function automatic logic [15:0] narrow_double(input logic [63:0] b);
      logic [15:0] sgn;
      logic [10:0] ex;
      logic [51:0] man;
      logic [63:0] m, h, r, halfway;
      int          e, s;
      sgn = {b[63], 15'd0};
      ex = b[62:52];
      man = b[51:0];
      if (ex == 11'h7FF) begin
         if (man != 52'd0) return sgn | 16'h7E00 | {6'd0, man[51:42]};
         return sgn | 16'h7C00;
      end
      if (ex == 11'd0) return sgn;
      e = int'(ex) - 1023;
      if (e > 15) return sgn | 16'h7C00;
      m = {11'd0, 1'b1, man};
      if (e >= -14) begin
         s = 42;
         h = (64'(e + 14) << 10) + (m >> 42);
      end else begin
         s = 28 - e;
         if (s >= 54) return sgn;
         h = m >> s;
      end
      r = m & ((64'd1 << s) - 64'd1);
      halfway = 64'd1 << (s - 1);
      if (r > halfway || (r == halfway && h[0])) h = h + 64'd1;
      if (h > 64'h7C00) h = 64'h7C00;
      return sgn | h[15:0];
   endfunction

   function automatic real widen_half(input logic [15:0] h);
      real d;
      if (h[14:10] == 5'd0) begin
         d = real'(h[9:0]) / 16777216.0;
         return h[15] ? -d : d;
      end
      if (h[14:10] == 5'h1F)
         return $bitstoreal({h[15], 11'h7FF, h[9:0], 42'd0});
      return $bitstoreal({h[15], 6'(h[14:10]) - 6'd15 + 11'd1023, h[9:0], 42'd0});
   endfunction

   function automatic logic nan16(input logic [15:0] h);
      return h[14:10] == 5'h1F && h[9:0] != 10'd0;
   endfunction

   function automatic logic inf16(input logic [15:0] h);
      return h[14:0] == 15'h7C00;
   endfunction

   function automatic logic [15:0] half_times(input logic [15:0] a, input logic [15:0] b);
      if (nan16(a)) return a | HALF_QUIET;
      if (nan16(b)) return b | HALF_QUIET;
      if ((inf16(a) && b[14:0] == 15'd0) || (inf16(b) && a[14:0] == 15'd0))
         return HALF_INVALID;
      return narrow_double($realtobits(widen_half(a) * widen_half(b)));
   endfunction

   function automatic logic [15:0] half_plus(input logic [15:0] a, input logic [15:0] b,
                                             input logic minus);
      if (nan16(a)) return a | HALF_QUIET;
      if (nan16(b)) return b | HALF_QUIET;
      if (inf16(a) && inf16(b) && ((a[15] ^ b[15]) != minus)) return HALF_INVALID;
      if (minus) return narrow_double($realtobits(widen_half(a) - widen_half(b)));
      return narrow_double($realtobits(widen_half(a) + widen_half(b)));
   endfunction

   function automatic rsp_word_type predict_product(input req_word_type w);
      rsp_word_type p;
      logic [15:0]  br, bi;
      br = narrow_double(scale_re);
      bi = narrow_double(scale_im);
      p.elem_real_half = narrow_double(w.elem_real_bits);
      p.elem_imag_half = narrow_double(w.elem_imag_bits);
      p.prod_real_half = half_plus(half_times(p.elem_real_half, br),
                                   half_times(p.elem_imag_half, bi), 1'b1);
      p.prod_imag_half = half_plus(half_times(p.elem_real_half, bi),
                                   half_times(p.elem_imag_half, br), 1'b0);
      return p;
   endfunction

   assign pending_count = product_queue.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         scale_re <= 64'd0;
         scale_im <= 64'd0;
         mismatch_count <= 0;
         product_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_SCALAR_REAL) scale_re <= csr_data;
            if (csr_index == CSR_SCALAR_IMAG) scale_im <= csr_data;
         end
         if (req_valid && req_ready) product_queue.push_back(predict_product(req_word));
         if (rsp_valid && rsp_ready) begin
            if (product_queue.size() == 0) begin
               $error("unexpected rsp word %h", rsp_word);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = product_queue.pop_front();
               if (want.elem_real_half !== rsp_word.elem_real_half)
                  $error("elem_real_half expected %h actual %h",
                         want.elem_real_half, rsp_word.elem_real_half);
               if (want.elem_imag_half !== rsp_word.elem_imag_half)
                  $error("elem_imag_half expected %h actual %h",
                         want.elem_imag_half, rsp_word.elem_imag_half);
               if (want.prod_real_half !== rsp_word.prod_real_half)
                  $error("prod_real_half expected %h actual %h",
                         want.prod_real_half, rsp_word.prod_real_half);
               if (want.prod_imag_half !== rsp_word.prod_imag_half)
                  $error("prod_imag_half expected %h actual %h",
                         want.prod_imag_half, rsp_word.prod_imag_half);
               if (want !== rsp_word) mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end
endmodule

// ----- sim/tb_fp16_complex_scale_multiply_core.sv -----
// Testbench top: drives elements and scalar writes into the complex scale multiplier.
module tb_fp16_complex_scale_multiply_core;
   import fcsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [0:0]   csr_index = CSR_SCALAR_REAL;
   logic [63:0]  csr_data = 64'd0;
   int           mismatch_count;
   int           pending_count;
   int           idle_max = 18;
   int           rsp_hold = 0;
   int           quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 5000;

   always #2 clock = ~clock;

   fp16_complex_scale_multiply_core dut (.*);
   fcsm_checker u_checker (.*);

   // result side: hold ready low for a drawn number of cycles per word
   always @(posedge clock) begin
      int hold;
      hold = rsp_hold;
      if (rsp_valid && rsp_ready) hold = $urandom_range(0, idle_max);
      if (hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold <= 0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(input logic [63:0] re, input logic [63:0] im);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{elem_real_bits: re, elem_imag_bits: im};
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic drain;
      // drop valid right after the last accepted word
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_scalar(input logic [63:0] re, input logic [63:0] im);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SCALAR_REAL;
      csr_data <= re;
      @(posedge clock);
      csr_index <= CSR_SCALAR_IMAG;
      csr_data <= im;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // mostly values in binary16 reach, some raw patterns and specials
   function automatic logic [63:0] draw_double();
      logic [63:0] raw;
      int          pick;
      raw = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 2) return raw;
      if (pick == 2) begin
         case ($urandom_range(0, 3))
            0: return {raw[63], 63'd0};
            1: return {raw[63], 11'h7FF, 52'd0};
            2: return {raw[63], 11'h7FF, raw[51:0] | 52'd1};
            default: return {raw[63], 11'd0, raw[51:0]};
         endcase
      end
      return {raw[63], 11'(1023 - 27 + $urandom_range(0, 44)), raw[51:0]};
   endfunction

   initial begin
      logic [63:0] corner[16];
      corner = '{64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
                 64'hFFF0000000000000, 64'h7FF4000000000001, 64'hFFF8000000000000,
                 64'h0000000000000001, 64'h40EFFC0000000000, 64'h40EFFE0000000000,
                 64'h40EFFDFFFFFFFFFF, 64'h3E70000000000000, 64'h3E60000000000000,
                 64'h3E68000000000000, 64'h3FF0020000000000, 64'h3FF0060000000000,
                 64'h7FEFFFFFFFFFFFFF};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // power-up scalar of zero
      send_word(64'h3FF0000000000000, 64'h7FF0000000000000);
      set_scalar(64'h3FF8000000000000, 64'hC000000000000000);
      for (int i = 0; i < 16; i++) send_word(corner[i], corner[15 - i]);
      set_scalar(64'h7FF0000000000000, 64'h7FF8000000000123);
      for (int i = 0; i < 4; i++) send_word(corner[i * 4], corner[i + 2]);
      set_scalar(64'h40EFFC0000000000, 64'h8000000000000001);
      for (int i = 0; i < 4; i++) send_word(corner[i + 7], corner[i * 3]);
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_scalar(64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF);
            1: set_scalar(64'hFFF0000000000000, 64'h3E70000000000000);
            2: set_scalar(64'hC0EFFC0000000000, 64'h40EFFC0000000000);
            default: set_scalar(draw_double(), draw_double());
         endcase
         idle_max = (phase % 3 == 1) ? 0 : 18;
         repeat (152) send_word(draw_double(), draw_double());
      end
      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ----- fp16_complex_scale_multiply_core.f -----
src/fcsm_pkg.sv
src/fcsm_mul.sv
src/fcsm_add.sv
src/fp16_complex_scale_multiply_core.sv
src/fcsm_checker.sv
sim/fcsm_checker.sv
sim/tb_fp16_complex_scale_multiply_core.sv
